/* hw/rtl/qrs_pkg.sv */
// qrs_pkg: request and response types, queue entry and shared constants
// used by every module of the quadratic root solver; no dependencies
`default_nettype none

package qrs_pkg;

  localparam int CW_MAX  = 24;              // widest supported coefficient
  localparam int DW_MAX  = 2 * CW_MAX + 2;  // discriminant magnitude width
  localparam int Q_DEPTH = 4;
  localparam int QCW     = 2;               // queue pointer width

  // solution counts
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
  } req_t;

  typedef struct packed {
    logic        [1:0]  solution_count;
    logic signed [47:0] root_plus;
    logic signed [47:0] root_minus;
    logic               zero_leading;
  } rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                     zero_a;
    logic [1:0]               cnt;
    logic signed [CW_MAX-1:0] a;
    logic signed [CW_MAX-1:0] b;
    logic [DW_MAX-1:0]        d;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/qrs_queue.sv */
// qrs_queue: small register queue between front and back
// depends on qrs_pkg
`default_nettype none

module qrs_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire qrs_pkg::entry_t   wdata,
  input  wire logic              pop,
  output qrs_pkg::entry_t        head,
  output logic                   empty,
  output logic [qrs_pkg::QCW:0]  count
);

  qrs_pkg::entry_t mem [qrs_pkg::Q_DEPTH];
  logic [qrs_pkg::QCW-1:0] wr_ptr;
  logic [qrs_pkg::QCW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (qrs_pkg::QCW+1)'(push) - (qrs_pkg::QCW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < (qrs_pkg::QCW+1)'(qrs_pkg::Q_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

/* hw/rtl/qrs_front.sv */
// qrs_front: accepts requests, forms the discriminant and classifies it
// depends on qrs_pkg
`default_nettype none

module qrs_front #(
  parameter int COEF_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire qrs_pkg::req_t    req,
  input  wire logic [qrs_pkg::QCW:0] q_count,
  output logic                  push,
  output qrs_pkg::entry_t       entry
);

  localparam int W  = COEF_WIDTH;
  localparam int IW = (W > 16) ? W : 16;
  localparam int DW = 2 * W + 3;

  logic [IW-1:0] ext_a, ext_b, ext_c;
  logic accept;

  logic v1, v2;
  logic signed [W-1:0] a1, b1, c1, a2, b2;
  logic signed [2*W-1:0] bb2, ac2;
  logic signed [DW-1:0] d;

  assign ext_a = IW'($unsigned(req.coef_a));
  assign ext_b = IW'($unsigned(req.coef_b));
  assign ext_c = IW'($unsigned(req.coef_c));

  // items in flight toward the queue must fit in it
  assign req_stall = (4'(q_count) + 4'(v1) + 4'(v2)) >= 4'(qrs_pkg::Q_DEPTH);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a1  <= $signed(ext_a[W-1:0]);
    b1  <= $signed(ext_b[W-1:0]);
    c1  <= $signed(ext_c[W-1:0]);
    bb2 <= b1 * b1;
    ac2 <= a1 * c1;
    a2  <= a1;
    b2  <= b1;
  end

  assign d    = DW'(bb2) - (DW'(ac2) <<< 2);
  assign push = v2;

  always_comb begin
    entry.zero_a = (a2 == '0);
    entry.a      = qrs_pkg::CW_MAX'(a2);
    entry.b      = qrs_pkg::CW_MAX'(b2);
    entry.d      = qrs_pkg::DW_MAX'(d[2*W:0]);
    if (entry.zero_a || d[DW-1]) begin
      entry.cnt = qrs_pkg::CNT_NONE;
    end else if (d == '0) begin
      entry.cnt = qrs_pkg::CNT_ONE;
    end else begin
      entry.cnt = qrs_pkg::CNT_TWO;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/qrs_back.sv */
// qrs_back: pipelined square root, numerator build, two restoring dividers
// and the output register; depends on qrs_pkg
`default_nettype none

module qrs_back #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire qrs_pkg::entry_t head,
  input  wire logic            q_empty,
  output logic                 pop,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output qrs_pkg::rsp_t        rsp
);

  localparam int W   = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW  = W + 1;
  localparam int SW  = 2 * RW;
  localparam int RMW = RW + 2;
  localparam int NW  = W + 3;
  localparam int MW  = W + 2;
  localparam int DVW = W + 1;
  localparam int DRW = DVW + 1;
  localparam int QW  = MW + F;
  localparam int EW  = (QW + 1 > 49) ? QW + 1 : 49;
  localparam logic signed [EW-1:0] RMAX = {{(EW-47){1'b0}}, {47{1'b1}}};
  localparam logic signed [EW-1:0] RMIN = ~RMAX;

  logic adv;
  assign adv = !rsp_valid || !rsp_stall;
  assign pop = adv && !q_empty;

  // square root stages
  logic                s_v    [RW];
  logic                s_za   [RW];
  logic [1:0]          s_cnt  [RW];
  logic signed [W-1:0] s_a    [RW];
  logic signed [W-1:0] s_b    [RW];
  logic [RMW-1:0]      s_rem  [RW];
  logic [RW-1:0]       s_root [RW];
  logic [SW-1:0]       s_x    [RW];

  logic                i_v    [RW];
  logic                i_za   [RW];
  logic [1:0]          i_cnt  [RW];
  logic signed [W-1:0] i_a    [RW];
  logic signed [W-1:0] i_b    [RW];
  logic [RMW-1:0]      i_rem  [RW];
  logic [RW-1:0]       i_root [RW];
  logic [SW-1:0]       i_x    [RW];
  logic [RMW-1:0]      n_rem  [RW];
  logic [RW-1:0]       n_root [RW];

  always_comb begin
    logic [RMW-1:0] rr;
    logic [RMW-1:0] t;
    i_v[0]    = !q_empty;
    i_za[0]   = head.zero_a;
    i_cnt[0]  = head.cnt;
    i_a[0]    = head.a[W-1:0];
    i_b[0]    = head.b[W-1:0];
    i_rem[0]  = '0;
    i_root[0] = '0;
    i_x[0]    = head.d[SW-1:0];
    for (int k = 1; k < RW; k++) begin
      i_v[k]    = s_v[k-1];
      i_za[k]   = s_za[k-1];
      i_cnt[k]  = s_cnt[k-1];
      i_a[k]    = s_a[k-1];
      i_b[k]    = s_b[k-1];
      i_rem[k]  = s_rem[k-1];
      i_root[k] = s_root[k-1];
      i_x[k]    = s_x[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      rr = {i_rem[k][RMW-3:0], i_x[k][SW-1:SW-2]};
      t  = {i_root[k], 2'b01};
      if (rr >= t) begin
        n_rem[k]  = rr - t;
        n_root[k] = {i_root[k][RW-2:0], 1'b1};
      end else begin
        n_rem[k]  = rr;
        n_root[k] = {i_root[k][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RW; k++) s_v[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < RW; k++) s_v[k] <= i_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < RW; k++) begin
        s_za[k]   <= i_za[k];
        s_cnt[k]  <= i_cnt[k];
        s_a[k]    <= i_a[k];
        s_b[k]    <= i_b[k];
        s_rem[k]  <= n_rem[k];
        s_root[k] <= n_root[k];
        s_x[k]    <= i_x[k] << 2;
      end
    end
  end

  // numerators and divisor magnitudes
  logic signed [NW-1:0] np, nm, den;
  logic signed [NW-1:0] abs_p, abs_m, abs_d;

  always_comb begin
    np    = -NW'(s_b[RW-1]) + $signed(NW'(s_root[RW-1]));
    nm    = -NW'(s_b[RW-1]) - $signed(NW'(s_root[RW-1]));
    den   = NW'(s_a[RW-1]) <<< 1;
    abs_p = np[NW-1]  ? -np  : np;
    abs_m = nm[NW-1]  ? -nm  : nm;
    abs_d = den[NW-1] ? -den : den;
  end

  logic           n_v, n_za, n_negp, n_negm;
  logic [1:0]     n_cnt;
  logic [MW-1:0]  n_magp, n_magm;
  logic [DVW-1:0] n_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else if (adv) begin
      n_v <= s_v[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_za   <= s_za[RW-1];
      n_cnt  <= s_cnt[RW-1];
      n_magp <= abs_p[MW-1:0];
      n_magm <= abs_m[MW-1:0];
      n_dv   <= abs_d[DVW-1:0];
      n_negp <= np[NW-1] ^ den[NW-1];
      n_negm <= nm[NW-1] ^ den[NW-1];
    end
  end

  // divider stages, one quotient bit per stage for each root
  logic           d_v    [QW];
  logic           d_za   [QW];
  logic [1:0]     d_cnt  [QW];
  logic           d_negp [QW];
  logic           d_negm [QW];
  logic [DVW-1:0] d_dv   [QW];
  logic [DRW-1:0] d_remp [QW];
  logic [DRW-1:0] d_remm [QW];
  logic [QW-1:0]  d_qp   [QW];
  logic [QW-1:0]  d_qm   [QW];
  logic [QW-1:0]  d_xp   [QW];
  logic [QW-1:0]  d_xm   [QW];

  logic           j_v    [QW];
  logic           j_za   [QW];
  logic [1:0]     j_cnt  [QW];
  logic           j_negp [QW];
  logic           j_negm [QW];
  logic [DVW-1:0] j_dv   [QW];
  logic [DRW-1:0] j_remp [QW];
  logic [DRW-1:0] j_remm [QW];
  logic [QW-1:0]  j_qp   [QW];
  logic [QW-1:0]  j_qm   [QW];
  logic [QW-1:0]  j_xp   [QW];
  logic [QW-1:0]  j_xm   [QW];
  logic [DRW-1:0] m_remp [QW];
  logic [DRW-1:0] m_remm [QW];
  logic [QW-1:0]  m_qp   [QW];
  logic [QW-1:0]  m_qm   [QW];

  always_comb begin
    logic [DRW-1:0] rp, rm;
    j_v[0]    = n_v;
    j_za[0]   = n_za;
    j_cnt[0]  = n_cnt;
    j_negp[0] = n_negp;
    j_negm[0] = n_negm;
    j_dv[0]   = n_dv;
    j_remp[0] = '0;
    j_remm[0] = '0;
    j_qp[0]   = '0;
    j_qm[0]   = '0;
    j_xp[0]   = QW'(n_magp) << F;
    j_xm[0]   = QW'(n_magm) << F;
    for (int k = 1; k < QW; k++) begin
      j_v[k]    = d_v[k-1];
      j_za[k]   = d_za[k-1];
      j_cnt[k]  = d_cnt[k-1];
      j_negp[k] = d_negp[k-1];
      j_negm[k] = d_negm[k-1];
      j_dv[k]   = d_dv[k-1];
      j_remp[k] = d_remp[k-1];
      j_remm[k] = d_remm[k-1];
      j_qp[k]   = d_qp[k-1];
      j_qm[k]   = d_qm[k-1];
      j_xp[k]   = d_xp[k-1];
      j_xm[k]   = d_xm[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      rp = {j_remp[k][DRW-2:0], j_xp[k][QW-1]};
      rm = {j_remm[k][DRW-2:0], j_xm[k][QW-1]};
      if (rp >= DRW'(j_dv[k])) begin
        m_remp[k] = rp - DRW'(j_dv[k]);
        m_qp[k]   = {j_qp[k][QW-2:0], 1'b1};
      end else begin
        m_remp[k] = rp;
        m_qp[k]   = {j_qp[k][QW-2:0], 1'b0};
      end
      if (rm >= DRW'(j_dv[k])) begin
        m_remm[k] = rm - DRW'(j_dv[k]);
        m_qm[k]   = {j_qm[k][QW-2:0], 1'b1};
      end else begin
        m_remm[k] = rm;
        m_qm[k]   = {j_qm[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) d_v[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < QW; k++) d_v[k] <= j_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QW; k++) begin
        d_za[k]   <= j_za[k];
        d_cnt[k]  <= j_cnt[k];
        d_negp[k] <= j_negp[k];
        d_negm[k] <= j_negm[k];
        d_dv[k]   <= j_dv[k];
        d_remp[k] <= m_remp[k];
        d_remm[k] <= m_remm[k];
        d_qp[k]   <= m_qp[k];
        d_qm[k]   <= m_qm[k];
        d_xp[k]   <= j_xp[k] << 1;
        d_xm[k]   <= j_xm[k] << 1;
      end
    end
  end

  // sign, saturation and output register
  logic signed [EW-1:0] sp, sm;
  logic signed [47:0]   rp_sat, rm_sat;
  logic                 has_root;

  always_comb begin
    sp = d_negp[QW-1] ? -$signed(EW'(d_qp[QW-1])) : $signed(EW'(d_qp[QW-1]));
    sm = d_negm[QW-1] ? -$signed(EW'(d_qm[QW-1])) : $signed(EW'(d_qm[QW-1]));
    if (sp > RMAX)      rp_sat = RMAX[47:0];
    else if (sp < RMIN) rp_sat = RMIN[47:0];
    else                rp_sat = sp[47:0];
    if (sm > RMAX)      rm_sat = RMAX[47:0];
    else if (sm < RMIN) rm_sat = RMIN[47:0];
    else                rm_sat = sm[47:0];
    has_root = (d_cnt[QW-1] != qrs_pkg::CNT_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= d_v[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.solution_count <= d_cnt[QW-1];
      rsp.zero_leading   <= d_za[QW-1];
      rsp.root_plus      <= has_root ? rp_sat : '0;
      if (!has_root) begin
        rsp.root_minus <= '0;
      end else if (d_cnt[QW-1] == qrs_pkg::CNT_ONE) begin
        rsp.root_minus <= rp_sat;
      end else begin
        rsp.root_minus <= rm_sat;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/quadratic_root_solver.sv */
// quadratic root solver: throughput is one request per cycle while req_stall and
// rsp_stall stay low; the root pipeline and the two dividers each retire one bit
// per stage, and a 4-entry queue decouples front and back
// reset (synchronous, active high) clears all valid bits and the queue pointers
`default_nettype none

module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire qrs_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output qrs_pkg::rsp_t      rsp
);

  // front to queue
  logic                   push;
  qrs_pkg::entry_t        entry;
  // queue to back
  qrs_pkg::entry_t        head;
  logic                   q_empty;
  logic                   pop;
  logic [qrs_pkg::QCW:0]  q_count;

  // front: input registers, the two products, discriminant and class
  qrs_front #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_count   (q_count),
    .push      (push),
    .entry     (entry)
  );

  // queue: front only issues when it has room, so push never overflows
  qrs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .count (q_count)
  );

  // back: square root, numerators, dividers, output register
  qrs_back #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // a zero leading coefficient never reports roots
  a_zero_a_no_roots: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.zero_leading) |->
      (rsp.solution_count == qrs_pkg::CNT_NONE && rsp.root_plus == '0
       && rsp.root_minus == '0))
    else $error("roots reported with zero leading coefficient");

  // a double root shows the same value on both outputs
  a_double_root: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.solution_count == qrs_pkg::CNT_ONE) |->
      (rsp.root_plus == rsp.root_minus))
    else $error("double root differs between outputs");

  // a stalled response stays put until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

`default_nettype wire

/* verif/quadratic_root_solver_test.sv */
// quadratic_root_solver_test: self-checking testbench for quadratic_root_solver
// drives coefficient requests and checks every response against a predictor
// depends on qrs_pkg and the quadratic_root_solver rtl
`default_nettype none

module quadratic_root_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LONG_HOLD  = 300;    // receiver hold-off, cycles
  localparam int  DRAIN_WAIT = 60;     // extra wait once nothing is owed
  localparam int  CYCLE_MAX  = 600000;
  localparam int  RAND_ITEMS = 1520;
  localparam longint ROOT_HI = 64'sd140737488355327;
  localparam longint ROOT_LO = -64'sd140737488355328;

  // one line of the directed table; known rows carry a hand-derived response
  typedef struct {
    qrs_pkg::req_t rq;
    bit            known;
    qrs_pkg::rsp_t rs;
  } row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  qrs_pkg::req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  qrs_pkg::rsp_t  rsp;

  qrs_pkg::rsp_t  pending_roots[$];   // responses still owed by the block, in order
  row_t  directed[$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    hold_long = 1'b0;   // asks the receiver for one long hold-off
  bit    sender_busy = 1'b0; // sender offers back to back in this stretch
  bit    sink_busy = 1'b0;   // receiver takes back to back in this stretch

  quadratic_root_solver dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #2 clk = ~clk;

  // floor of the square root, bit by bit
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // numerator scaled to 16 fraction bits, divided toward zero, clamped
  function automatic logic signed [47:0] fixed_root(longint num, longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > ROOT_HI) q = ROOT_HI;
    if (q < ROOT_LO) q = ROOT_LO;
    return q[47:0];
  endfunction

  function automatic qrs_pkg::rsp_t solve_roots(qrs_pkg::req_t r);
    longint a, b, c, disc, s;
    qrs_pkg::rsp_t o;
    a = r.coef_a;
    b = r.coef_b;
    c = r.coef_c;
    o = '0;
    o.solution_count = qrs_pkg::CNT_NONE;
    if (a == 0) begin
      o.zero_leading = 1'b1;
      return o;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) return o;
    if (disc == 0) begin
      o.solution_count = qrs_pkg::CNT_ONE;
      o.root_plus  = fixed_root(-b, 2 * a);
      o.root_minus = o.root_plus;
      return o;
    end
    s = longint'(floor_sqrt(longint'(disc)));
    o.solution_count = qrs_pkg::CNT_TWO;
    o.root_plus  = fixed_root(-b + s, 2 * a);
    o.root_minus = fixed_root(-b - s, 2 * a);
    return o;
  endfunction

  function automatic void add_row(int a, int b, int c, bit known,
                                  logic [1:0] cnt, longint rp, longint rm, bit zl);
    row_t w;
    w.rq.coef_a = a[15:0];
    w.rq.coef_b = b[15:0];
    w.rq.coef_c = c[15:0];
    w.known = known;
    w.rs.solution_count = cnt;
    w.rs.root_plus  = rp[47:0];
    w.rs.root_minus = rm[47:0];
    w.rs.zero_leading = zl;
    directed.push_back(w);
  endfunction

  function automatic int any16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // offer one request, wait for acceptance, then record what it must produce
  task automatic send(qrs_pkg::req_t r, qrs_pkg::rsp_t owed);
    int gap;
    gap = sender_busy ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && !req_stall));
    pending_roots.push_back(owed);
  endtask

  task automatic wait_empty();
    req_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // random coefficients, weighted toward cases that reach every root path
  function automatic qrs_pkg::req_t pick_request();
    qrs_pkg::req_t r;
    int   a, b, c, k, m;
    a = any16();
    b = any16();
    c = any16();
    case ($urandom_range(0, 9))
      4, 5: begin
        a = $urandom_range(0, 40) - 20;
        b = $urandom_range(0, 40) - 20;
        c = $urandom_range(0, 40) - 20;
      end
      6: begin  // perfect square: one root
        k = $urandom_range(1, 8);
        if ($urandom_range(0, 1)) k = -k;
        m = $urandom_range(0, 80) - 40;
        a = k;
        b = 2 * k * m;
        c = k * m * m;
      end
      7: a = 0;
      8: begin  // opposite signs of a and c: two roots
        a = $urandom_range(1, 32767);
        c = -int'($urandom_range(1, 32768));
        if ($urandom_range(0, 1)) begin
          a = -a;
          c = $urandom_range(1, 32767);
        end
      end
      9: a = $urandom_range(0, 6) - 3;
      default: ;
    endcase
    r.coef_a = a[15:0];
    r.coef_b = b[15:0];
    r.coef_c = c[15:0];
    return r;
  endfunction

  // cycle limit guards against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_MAX) begin
      $display("quadratic_root_solver verification failed");
      $finish;
    end
  end

  // response side: random stall per response, one long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_long) n = LONG_HOLD;
      else n = sink_busy ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        hold_long = 1'b0;
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  // compare every accepted response with the oldest owed one
  always @(posedge clk) begin
    qrs_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp);
      end else begin
        want = pending_roots.pop_front();
        if (rsp.solution_count !== want.solution_count ||
            rsp.root_plus !== want.root_plus ||
            rsp.root_minus !== want.root_minus ||
            rsp.zero_leading !== want.zero_leading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, rsp);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero leading coefficient
    add_row(0, 5, 7, 1, qrs_pkg::CNT_NONE, 0, 0, 1);
    add_row(0, -32768, -32768, 1, qrs_pkg::CNT_NONE, 0, 0, 1);
    add_row(0, 32767, 32767, 1, qrs_pkg::CNT_NONE, 0, 0, 1);
    // negative discriminant
    add_row(1, 0, 1, 1, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(32767, 32767, 32767, 1, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(-32768, -32768, -32768, 1, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(-1, -1, -1, 1, qrs_pkg::CNT_NONE, 0, 0, 0);
    // zero discriminant
    add_row(1, 2, 1, 1, qrs_pkg::CNT_ONE, -65536, -65536, 0);
    add_row(-32768, 0, 0, 1, qrs_pkg::CNT_ONE, 0, 0, 0);
    add_row(3, -12, 12, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    // two roots
    add_row(1, 0, -1, 1, qrs_pkg::CNT_TWO, 65536, -65536, 0);
    add_row(-1, 0, 1, 1, qrs_pkg::CNT_TWO, -65536, 65536, 0);
    add_row(3, 7, 2, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(2, 3, -5, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(1, -1, -1, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(5, 32767, 0, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(1, -32768, -32768, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(1, -32768, 0, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(-32768, -32768, 32767, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(32767, -32768, -32768, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(-32768, 32767, 32767, 0, qrs_pkg::CNT_NONE, 0, 0, 0);
    add_row(1, 32767, -32768, 0, qrs_pkg::CNT_NONE, 0, 0, 0);

    foreach (directed[i])
      send(directed[i].rq, directed[i].known ? directed[i].rs
                                              : solve_roots(directed[i].rq));

    for (int i = 0; i < RAND_ITEMS; i++) begin
      qrs_pkg::req_t r;
      // alternate stretches of back-to-back traffic and random gaps
      if (i % 50 == 0 && (i < 800 || i >= 900)) begin
        sender_busy = ($urandom_range(0, 3) == 0);
        sink_busy = ($urandom_range(0, 3) == 0);
      end
      // sender pause until everything owed has come back
      if (i == 500) wait_empty();
      // long receiver hold-off while requests keep coming, filling the block
      if (i == 800) begin
        sender_busy = 1'b1;
        hold_long = 1'b1;
      end
      r = pick_request();
      send(r, solve_roots(r));
    end
    req_valid <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0)
      $display("quadratic_root_solver verification clean");
    else
      $display("quadratic_root_solver verification failed");
    $finish;
  end

endmodule

`default_nettype wire
